// File: hw/rtl/sffp_pkg.sv
// ----------------------------------------------------------------------------
// sffp_pkg: shared types and constants of the sync-framed packet parser
// Frame phase codes, status codes, frame bytes and the result record.
// ----------------------------------------------------------------------------
package sffp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned TYPE_W   = 2;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  // Frame phases; unused codes behave like PH_SYNC1.
  localparam logic [PHASE_W-1:0] PH_SYNC1   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SYNC2   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_TYPE    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_COUNT   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;
  localparam logic [PHASE_W-1:0] PH_TRAIL1  = 3'd5;
  localparam logic [PHASE_W-1:0] PH_TRAIL2  = 3'd6;

  localparam logic [STATUS_W-1:0] ST_NONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SYNC1 = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_SYNC2 = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_TYPE  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 3'd5;
  localparam logic [STATUS_W-1:0] ST_BAD_TRL1  = 3'd6;

  localparam logic [TYPE_W-1:0] FT_NONE   = 2'd0;
  localparam logic [TYPE_W-1:0] FT_ARRIVE = 2'd1;
  localparam logic [TYPE_W-1:0] FT_ENEMY  = 2'd2;

  localparam logic [BYTE_W-1:0] SYNC1_BYTE  = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC2_BYTE  = 8'h00;
  localparam logic [BYTE_W-1:0] TRAIL1_BYTE = 8'h00;
  localparam logic [BYTE_W-1:0] TRAIL2_BYTE = 8'hAA;
  localparam logic [BYTE_W-1:0] TYPE_NONE   = 8'h00;
  localparam logic [BYTE_W-1:0] TYPE_ARRIVE = 8'h01;
  localparam logic [BYTE_W-1:0] TYPE_BLUE   = 8'h09;
  localparam logic [BYTE_W-1:0] TYPE_RED    = 8'h0A;

  localparam logic [BYTE_W-1:0] MAX_COUNT_RESET = 8'd20;

  // Register index in the configuration space.
  localparam logic [0:0] REG_MAX_COUNT = 1'b0;

  typedef struct packed {
    logic [STATUS_W-1:0] frame_status;
    logic                word_valid;
    logic [WORD_W-1:0]   word_data;
    logic [BYTE_W-1:0]   word_index;
    logic [TYPE_W-1:0]   frame_type;
    logic                enemy_red;
    logic [BYTE_W-1:0]   word_count;
  } result_t;

endpackage

// File: hw/rtl/sync_framed_float_packet_parser.sv
// ----------------------------------------------------------------------------
// sync_framed_float_packet_parser: byte-stream frame parser
// Checks sync/type/count/payload/trailer frames and emits payload words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one received byte per item on rx_byte, taken at a clock
//   edge with in_valid high and in_stall low.
//   Output channel: exactly one result item per input byte (status, any
//   completed payload word with its index, frame type, colour bit, count),
//   taken at an edge with out_valid high and out_stall low.
//   Configuration: APB write to byte address 0 sets max_word_count
//   (reset 20); write only while no byte is in flight.
//   Path: the accepted byte passes the input register, then the result
//   register; the frame decode sits between the two.
//   Throughput: one byte per clock while out_stall is low.
//   Reset: synchronous; both registers empty, parser waits for first sync.
//   Stall: a stalled result holds; the input register fills behind it and
//   then in_stall rises until the receiver takes the result.
// ----------------------------------------------------------------------------
module sync_framed_float_packet_parser (
  input  logic                          clk,
  input  logic                          rst,
  // byte input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sffp_pkg::BYTE_W-1:0]   rx_byte,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sffp_pkg::STATUS_W-1:0] frame_status,
  output logic                          word_valid,
  output logic [sffp_pkg::WORD_W-1:0]   word_data,
  output logic [sffp_pkg::BYTE_W-1:0]   word_index,
  output logic [sffp_pkg::TYPE_W-1:0]   frame_type,
  output logic                          enemy_red,
  output logic [sffp_pkg::BYTE_W-1:0]   word_count,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sffp_pkg::APB_AW-1:0]   paddr,
  input  logic [sffp_pkg::APB_DW-1:0]   pwdata,
  output logic [sffp_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import sffp_pkg::*;

  logic              byte_vld;
  logic [BYTE_W-1:0] byte_q;
  logic [BYTE_W-1:0] max_count;
  logic              step;
  logic              can_load;
  logic              reg_hit;
  result_t           res_comb;
  result_t           res_q;

  // Configuration register; the register index is the word address.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1:2] == REG_MAX_COUNT);
  assign prdata  = reg_hit ? {{(APB_DW-BYTE_W){1'b0}}, max_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_count <= MAX_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_count <= pwdata[BYTE_W-1:0];
    end
  end

  // Decode the held byte whenever the result register can take it.
  assign step     = byte_vld && can_load;
  // Hold the input while the held byte cannot move on.
  assign in_stall = byte_vld && !can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else if (!in_stall) begin
      byte_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q <= rx_byte;
    end
  end

  sffp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (byte_q),
    .max_count (max_count),
    .res       (res_comb)
  );

  sffp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_in    (res_comb),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .can_load  (can_load),
    .res_out   (res_q)
  );

  assign frame_status = res_q.frame_status;
  assign word_valid   = res_q.word_valid;
  assign word_data    = res_q.word_data;
  assign word_index   = res_q.word_index;
  assign frame_type   = res_q.frame_type;
  assign enemy_red    = res_q.enemy_red;
  assign word_count   = res_q.word_count;

  a_stall_needs_held_byte: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> byte_vld)
    else $error("input stalled with nothing held");

  a_no_step_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !step)
    else $error("byte decoded while result register blocked");

  a_reset_max_count: assert property (@(posedge clk)
    rst |=> (max_count == MAX_COUNT_RESET))
    else $error("max word count not restored by reset");

  a_step_yields_result: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("decoded byte produced no result item");

endmodule

// File: hw/rtl/sffp_parse.sv
// ----------------------------------------------------------------------------
// sffp_parse: frame state and per-byte decode
// Holds the frame phase and word assembly state; computes one result per byte.
// ----------------------------------------------------------------------------
module sffp_parse (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [sffp_pkg::BYTE_W-1:0] rx_byte,
  input  logic [sffp_pkg::BYTE_W-1:0] max_count,
  output sffp_pkg::result_t           res
);
  import sffp_pkg::*;

  logic [PHASE_W-1:0] phase, phase_next;
  logic [TYPE_W-1:0]  type_code, type_code_next;
  logic               colour_bit, colour_bit_next;
  logic [BYTE_W-1:0]  expected_words, expected_words_next;
  logic [BYTE_W-1:0]  words_done, words_done_next;
  logic [1:0]         byte_position, byte_position_next;
  logic [23:0]        partial_word, partial_word_next;

  always_comb begin
    phase_next          = phase;
    type_code_next      = type_code;
    colour_bit_next     = colour_bit;
    expected_words_next = expected_words;
    words_done_next     = words_done;
    byte_position_next  = byte_position;
    partial_word_next   = partial_word;
    res                 = '0;

    case (phase)
      PH_SYNC2: begin
        if (rx_byte == SYNC2_BYTE) begin
          phase_next = PH_TYPE;
        end else begin
          phase_next       = PH_SYNC1;
          res.frame_status = ST_BAD_SYNC2;
        end
      end
      PH_TYPE: begin
        phase_next = PH_COUNT;
        case (rx_byte)
          TYPE_BLUE: begin
            type_code_next  = FT_ENEMY;
            colour_bit_next = 1'b0;
          end
          TYPE_RED: begin
            type_code_next  = FT_ENEMY;
            colour_bit_next = 1'b1;
          end
          TYPE_ARRIVE: type_code_next = FT_ARRIVE;
          TYPE_NONE:   type_code_next = FT_NONE;
          default: begin
            phase_next       = PH_SYNC1;
            res.frame_status = ST_BAD_TYPE;
          end
        endcase
      end
      PH_COUNT: begin
        expected_words_next = rx_byte;
        words_done_next     = '0;
        byte_position_next  = '0;
        partial_word_next   = '0;
        if (rx_byte > max_count) begin
          phase_next       = PH_SYNC1;
          res.frame_status = ST_BAD_COUNT;
        end else if (rx_byte == '0) begin
          phase_next = PH_TRAIL1;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (byte_position == 2'd3) begin
          // last byte of the word: emit and advance the word counter
          res.word_valid     = 1'b1;
          res.word_data      = {rx_byte, partial_word};
          res.word_index     = words_done;
          words_done_next    = words_done + 8'd1;
          byte_position_next = '0;
          partial_word_next  = '0;
          if (words_done_next == expected_words) begin
            phase_next = PH_TRAIL1;
          end
        end else begin
          case (byte_position)
            2'd0:    partial_word_next[7:0]   = rx_byte;
            2'd1:    partial_word_next[15:8]  = rx_byte;
            default: partial_word_next[23:16] = rx_byte;
          endcase
          byte_position_next = byte_position + 2'd1;
        end
      end
      PH_TRAIL1: begin
        if (rx_byte == TRAIL1_BYTE) begin
          phase_next = PH_TRAIL2;
        end else begin
          phase_next       = PH_SYNC1;
          res.frame_status = ST_BAD_TRL1;
        end
      end
      PH_TRAIL2: begin
        // a bad final byte drops the frame without a report
        if (rx_byte == TRAIL2_BYTE) begin
          res.frame_status = ST_OK;
        end
        phase_next = PH_SYNC1;
      end
      default: begin
        if (rx_byte == SYNC1_BYTE) begin
          phase_next          = PH_SYNC2;
          type_code_next      = FT_NONE;
          expected_words_next = '0;
          words_done_next     = '0;
          byte_position_next  = '0;
          partial_word_next   = '0;
        end else begin
          phase_next       = PH_SYNC1;
          res.frame_status = ST_BAD_SYNC1;
        end
      end
    endcase

    res.frame_type = type_code_next;
    res.enemy_red  = colour_bit_next;
    res.word_count = expected_words_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SYNC1;
      type_code      <= FT_NONE;
      colour_bit     <= 1'b0;
      expected_words <= '0;
      words_done     <= '0;
      byte_position  <= '0;
      partial_word   <= '0;
    end else if (step) begin
      phase          <= phase_next;
      type_code      <= type_code_next;
      colour_bit     <= colour_bit_next;
      expected_words <= expected_words_next;
      words_done     <= words_done_next;
      byte_position  <= byte_position_next;
      partial_word   <= partial_word_next;
    end
  end

  a_word_only_in_payload: assert property (@(posedge clk) disable iff (rst)
    (step && res.word_valid) |-> (phase == PH_PAYLOAD))
    else $error("word emitted outside payload phase");

  a_ok_only_at_trailer: assert property (@(posedge clk) disable iff (rst)
    (step && (res.frame_status == ST_OK)) |=> (phase == PH_SYNC1))
    else $error("frame accepted without returning to sync wait");

  a_sync_starts_frame: assert property (@(posedge clk) disable iff (rst)
    (step && (phase == PH_SYNC1) && (rx_byte == SYNC1_BYTE))
      |=> (phase == PH_SYNC2) && (words_done == '0))
    else $error("sync byte did not start a frame");

endmodule

// File: hw/rtl/sffp_out_reg.sv
// ----------------------------------------------------------------------------
// sffp_out_reg: result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module sffp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  sffp_pkg::result_t res_in,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              can_load,
  output sffp_pkg::result_t res_out
);
  import sffp_pkg::*;

  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      res_out <= res_in;
    end
  end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sync_framed_float_packet_parser
// Streams framed and corrupted byte sequences under random idling and
// stalling, predicts every result item and compares each field of it.
// ----------------------------------------------------------------------------
module testbench;
  import sffp_pkg::*;

  // Clock, reset and every block input start at a known value.
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic [BYTE_W-1:0]   rx_byte   = '0;
  logic                out_stall = 1'b0;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [APB_AW-1:0]   paddr     = '0;
  logic [APB_DW-1:0]   pwdata    = '0;

  logic                in_stall;
  logic                out_valid;
  logic [STATUS_W-1:0] frame_status;
  logic                word_valid;
  logic [WORD_W-1:0]   word_data;
  logic [BYTE_W-1:0]   word_index;
  logic [TYPE_W-1:0]   frame_type;
  logic                enemy_red;
  logic [BYTE_W-1:0]   word_count;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  sync_framed_float_packet_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_status (frame_status),
    .word_valid   (word_valid),
    .word_data    (word_data),
    .word_index   (word_index),
    .frame_type   (frame_type),
    .enemy_red    (enemy_red),
    .word_count   (word_count),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser shadow: own copy of the frame state and of max_word_count.
  // --------------------------------------------------------------------------
  logic [PHASE_W-1:0] ph          = PH_SYNC1;
  logic [TYPE_W-1:0]  cur_type    = FT_NONE;
  logic               colour_red  = 1'b0;
  logic [BYTE_W-1:0]  words_due   = '0;
  logic [BYTE_W-1:0]  words_done  = '0;
  logic [1:0]         byte_pos    = '0;
  logic [23:0]        partial     = '0;
  logic [BYTE_W-1:0]  max_lim     = MAX_COUNT_RESET;

  result_t     due_results [$];   // predicted result items, oldest first
  int unsigned n_bad       = 0;
  int unsigned n_bytes     = 0;   // input items accepted so far
  int unsigned n_results   = 0;
  int unsigned gap_pct     = 0;   // sender idle chance per cycle, percent
  int unsigned stall_pct   = 0;   // receiver stall chance per cycle, percent

  // Override for directed rows whose result is typed into the table.
  bit          row_typed   = 1'b0;
  result_t     row_want    = '0;

  logic [BYTE_W-1:0] type_bytes [4] = '{TYPE_NONE, TYPE_ARRIVE, TYPE_BLUE, TYPE_RED};

  // Advance the shadow by one received byte and return the result item it causes.
  function automatic result_t parse_byte(input logic [BYTE_W-1:0] b);
    result_t r;
    r = '0;
    case (ph)
      PH_SYNC2: begin
        if (b == SYNC2_BYTE) begin
          ph = PH_TYPE;
        end else begin
          ph = PH_SYNC1;
          r.frame_status = ST_BAD_SYNC2;
        end
      end
      PH_TYPE: begin
        ph = PH_COUNT;
        if (b == TYPE_BLUE) begin
          cur_type   = FT_ENEMY;
          colour_red = 1'b0;
        end else if (b == TYPE_RED) begin
          cur_type   = FT_ENEMY;
          colour_red = 1'b1;
        end else if (b == TYPE_ARRIVE) begin
          cur_type = FT_ARRIVE;
        end else if (b == TYPE_NONE) begin
          cur_type = FT_NONE;
        end else begin
          ph = PH_SYNC1;
          r.frame_status = ST_BAD_TYPE;
        end
      end
      PH_COUNT: begin
        words_due  = b;
        words_done = '0;
        byte_pos   = '0;
        partial    = '0;
        if (b > max_lim) begin
          ph = PH_SYNC1;
          r.frame_status = ST_BAD_COUNT;
        end else if (b == 0) begin
          ph = PH_TRAIL1;
        end else begin
          ph = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (byte_pos == 2'd3) begin
          r.word_valid = 1'b1;
          r.word_data  = {b, partial};
          r.word_index = words_done;
          words_done   = words_done + 1'b1;
          byte_pos     = '0;
          partial      = '0;
          if (words_done == words_due) ph = PH_TRAIL1;
        end else begin
          partial[8*byte_pos +: 8] = b;
          byte_pos = byte_pos + 1'b1;
        end
      end
      PH_TRAIL1: begin
        if (b == TRAIL1_BYTE) begin
          ph = PH_TRAIL2;
        end else begin
          ph = PH_SYNC1;
          r.frame_status = ST_BAD_TRL1;
        end
      end
      PH_TRAIL2: begin
        // a wrong final byte drops the frame without an error code
        if (b == TRAIL2_BYTE) r.frame_status = ST_OK;
        ph = PH_SYNC1;
      end
      default: begin
        // unused phase codes fall in here too and act like waiting for sync
        if (b == SYNC1_BYTE) begin
          ph         = PH_SYNC2;
          cur_type   = FT_NONE;
          words_due  = '0;
          words_done = '0;
          byte_pos   = '0;
          partial    = '0;
        end else begin
          ph = PH_SYNC1;
          r.frame_status = ST_BAD_SYNC1;
        end
      end
    endcase
    r.frame_type = cur_type;
    r.enemy_red  = colour_red;
    r.word_count = words_due;
    return r;
  endfunction

  function automatic string fmt_res(input result_t r);
    return $sformatf("st=%0d wv=%0d data=%h idx=%0d type=%0d red=%0d cnt=%0d",
                     r.frame_status, r.word_valid, r.word_data, r.word_index,
                     r.frame_type, r.enemy_red, r.word_count);
  endfunction

  // Count a failure; report only the first ten.
  task automatic note_fail(input string msg);
    n_bad++;
    if (n_bad <= 10) $display("%s", msg);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: check the result item first, then predict for the new input item,
  // so a result and an input item on the same edge keep their order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got;
    result_t want;
    result_t pred;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {frame_status, word_valid, word_data, word_index,
               frame_type, enemy_red, word_count};
        n_results++;
        if (due_results.size() == 0) begin
          note_fail($sformatf("result %0d arrived with nothing due: %s",
                              n_results, fmt_res(got)));
        end else begin
          want = due_results.pop_front();
          if (got.frame_status !== want.frame_status ||
              got.word_valid   !== want.word_valid   ||
              got.word_data    !== want.word_data    ||
              got.word_index   !== want.word_index   ||
              got.frame_type   !== want.frame_type   ||
              got.enemy_red    !== want.enemy_red    ||
              got.word_count   !== want.word_count) begin
            note_fail($sformatf("result %0d mismatch: want %s / got %s",
                                n_results, fmt_res(want), fmt_res(got)));
          end
        end
      end
      if (in_valid && !in_stall) begin
        pred = parse_byte(rx_byte);
        if (row_typed) pred = row_want;
        due_results = {due_results, pred};
      end
    end
  end

  // Receiver: stall at random at the falling edge.
  always @(negedge clk) begin
    out_stall = !rst && ($urandom_range(99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // Sender and configuration tasks
  // --------------------------------------------------------------------------

  // Idle at random, then present one item and hold it until it is taken.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed,
                           input result_t want);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      rx_byte  = BYTE_W'($urandom);
      @(negedge clk);
    end
    row_typed = typed;
    row_want  = want;
    in_valid  = 1'b1;
    rx_byte   = b;
    do @(posedge clk); while (in_stall);
    n_bytes++;
  endtask

  // Drop valid and wait until every due result item has come, plus the latency.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One APB transfer to the count limit register: setup, then access.
  task automatic apb_access(input bit wr, input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = APB_AW'(REG_MAX_COUNT) << 2;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_max_count(input logic [BYTE_W-1:0] v);
    logic [APB_DW-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== APB_DW'(v))
      note_fail($sformatf("max_word_count read %h, want %h", rd, v));
  endtask

  task automatic set_max_count(input logic [BYTE_W-1:0] v);
    logic [APB_DW-1:0] rd;
    apb_access(1'b1, APB_DW'(v), rd);
    max_lim = v;
    check_max_count(v);
  endtask

  // Build one frame with random content, maybe break it, and send it.
  task automatic send_frame(input bit forced, input logic [BYTE_W-1:0] forced_cnt);
    logic [BYTE_W-1:0] f [$];
    logic [BYTE_W-1:0] cnt;
    logic [BYTE_W-1:0] b;
    int unsigned       kind;
    int unsigned       cap;
    int unsigned       cut;
    kind = forced ? 0 : $urandom_range(99);
    if (kind >= 95) begin
      // line noise between frames
      repeat ($urandom_range(4, 1)) send_byte(BYTE_W'($urandom), 1'b0, '0);
      return;
    end
    // keep most frames short; hit the limit itself when it is small
    cap = (max_lim < 4) ? max_lim : 4;
    if (forced) cnt = forced_cnt;
    else if (max_lim == 0) cnt = '0;
    else if ($urandom_range(99) < 80) cnt = BYTE_W'($urandom_range(cap, 0));
    else cnt = (max_lim <= 8) ? max_lim : BYTE_W'($urandom_range(8, cap));
    f = {f, SYNC1_BYTE};
    f = {f, SYNC2_BYTE};
    f = {f, type_bytes[$urandom_range(3)]};
    f = {f, cnt};
    repeat (4 * cnt) f = {f, BYTE_W'($urandom)};
    f = {f, TRAIL1_BYTE};
    f = {f, TRAIL2_BYTE};
    if (kind >= 60 && kind < 66) begin
      f[1] = BYTE_W'($urandom_range(255, 1));
    end else if (kind >= 66 && kind < 72) begin
      do b = BYTE_W'($urandom);
      while (b inside {TYPE_NONE, TYPE_ARRIVE, TYPE_BLUE, TYPE_RED});
      f[2] = b;
    end else if (kind >= 72 && kind < 78 && max_lim < 255) begin
      // the payload behind an oversized count turns into noise
      f[3] = BYTE_W'($urandom_range(255, max_lim + 1));
    end else if (kind >= 78 && kind < 84) begin
      f[f.size()-2] = BYTE_W'($urandom_range(255, 1));
    end else if (kind >= 84 && kind < 90) begin
      b = BYTE_W'($urandom_range(254, 0));
      if (b >= TRAIL2_BYTE) b = b + 1'b1;
      f[f.size()-1] = b;
    end else if (kind >= 90) begin
      cut = $urandom_range(f.size() - 1, 1);
      while (f.size() > cut) void'(f.pop_back());
    end
    foreach (f[i]) send_byte(f[i], 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Directed rows: fixed results only where they follow from the frame rules
  // at a glance; the rest go through the shadow parser.
  // --------------------------------------------------------------------------
  typedef struct {
    logic [BYTE_W-1:0] b;
    bit                typed;
    result_t           want;
  } dir_row_t;

  dir_row_t dir_rows [25] = '{
    '{8'hFF, 1'b1, '{ST_BAD_SYNC1, 1'b0, 32'h0, 8'h0, FT_NONE,  1'b0, 8'd0}},
    '{8'h55, 1'b1, '{ST_NONE,      1'b0, 32'h0, 8'h0, FT_NONE,  1'b0, 8'd0}},
    '{8'h01, 1'b1, '{ST_BAD_SYNC2, 1'b0, 32'h0, 8'h0, FT_NONE,  1'b0, 8'd0}},
    '{8'h55, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h07, 1'b1, '{ST_BAD_TYPE,  1'b0, 32'h0, 8'h0, FT_NONE,  1'b0, 8'd0}},
    '{8'h55, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h0A, 1'b1, '{ST_NONE,      1'b0, 32'h0, 8'h0, FT_ENEMY, 1'b1, 8'd0}},
    '{8'h15, 1'b1, '{ST_BAD_COUNT, 1'b0, 32'h0, 8'h0, FT_ENEMY, 1'b1, 8'd21}},
    '{8'h55, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h09, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hAA, 1'b1, '{ST_OK,        1'b0, 32'h0, 8'h0, FT_ENEMY, 1'b0, 8'd1}},
    '{8'h55, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h80, 1'b1, '{ST_BAD_TRL1,  1'b0, 32'h0, 8'h0, FT_ARRIVE, 1'b0, 8'd0}}
  };

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // After reset the limit reads back as its reset value.
    check_max_count(MAX_COUNT_RESET);

    // Sender idles rarely, receiver stalls often.
    gap_pct   = 6;
    stall_pct = 62;
    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);
    row_typed = 1'b0;

    while (n_bytes < 110) send_frame(1'b0, '0);
    // Hold the sender until the block has emptied out, then go on mid-stream.
    drain();
    while (n_bytes < 170) send_frame(1'b0, '0);

    // Zero limit: only empty frames get through. Roles of the two sides swap.
    drain();
    set_max_count(8'd0);
    gap_pct   = 62;
    stall_pct = 6;
    while (n_bytes < 250) send_frame(1'b0, '0);

    // Full limit, no idling; one frame carries a long payload.
    drain();
    set_max_count(8'd255);
    gap_pct   = 0;
    stall_pct = 0;
    while (n_bytes < 290) send_frame(1'b0, '0);
    send_frame(1'b1, 8'd60);
    while (n_bytes < 560) send_frame(1'b0, '0);

    // Small random limit so frames often sit right at it.
    drain();
    set_max_count(BYTE_W'($urandom_range(8, 1)));
    while (n_bytes < 610) send_frame(1'b0, '0);

    drain();
    if (n_bad == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
